@@ design/b36e_pkg.sv @@
`default_nettype none
package b36e_pkg;

	localparam int unsigned RADIX      = 36;
	localparam int unsigned DIGIT_W    = 6;
	localparam int unsigned CHAR_W     = 7;
	localparam int unsigned VALUE_W    = 128;
	localparam int unsigned SLICE_W    = 16;
	localparam int unsigned SLICES     = VALUE_W / SLICE_W;
	localparam int unsigned SLICE_IDXW = $clog2(SLICES);
	localparam int unsigned DIVIDEND_W = DIGIT_W + SLICE_W;

	// ceil(2^32 / 36); exact floor division for any dividend below 2^27
	localparam int unsigned RECIP_W     = 27;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP = 27'd119304648;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 7'd87; // 'a' minus ten
	localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

	typedef struct packed {
		logic [SLICE_W-1:0] quot;
		logic [DIGIT_W-1:0] rem;
	} div_res_t;

	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {1'b0, d};
		if (d < DEC_DIGITS) begin
			return CHAR_ZERO + d_ext;
		end
		return CHAR_ALPHA + d_ext;
	endfunction

endpackage
`default_nettype wire

@@ design/b36e_div_step.sv @@
`default_nettype none
// One radix-36 long-division step over a 16-bit slice: reciprocal multiply.
module b36e_div_step (
	input  wire logic [b36e_pkg::DIGIT_W-1:0] rem_in,
	input  wire logic [b36e_pkg::SLICE_W-1:0] slice,
	output b36e_pkg::div_res_t               res
);

	localparam int unsigned PROD_W = b36e_pkg::DIVIDEND_W + b36e_pkg::RECIP_W;

	logic [b36e_pkg::DIVIDEND_W-1:0] dividend;
	logic [PROD_W-1:0]               prod;
	logic [b36e_pkg::SLICE_W-1:0]    quot;
	logic [b36e_pkg::DIGIT_W-1:0]    quot_x36;

	assign dividend = {rem_in, slice};
	assign prod     = PROD_W'(dividend) * PROD_W'(b36e_pkg::RECIP);
	assign quot     = prod[b36e_pkg::RECIP_SHIFT +: b36e_pkg::SLICE_W];

	// remainder is below 36, so only the low six bits of 36*q matter
	assign quot_x36 = b36e_pkg::DIGIT_W'({quot, 5'b0} + {quot, 2'b0});

	assign res.quot = quot;
	assign res.rem  = dividend[b36e_pkg::DIGIT_W-1:0] - quot_x36;

endmodule
`default_nettype wire

@@ design/b36e_digit_ram.sv @@
`default_nettype none
module b36e_digit_ram #(
	parameter int unsigned DEPTH = 25
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire logic [b36e_pkg::DIGIT_W-1:0] wr_data,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic      [b36e_pkg::DIGIT_W-1:0] rd_data
);

	logic [b36e_pkg::DIGIT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/base36_encode_128_unit.sv @@
`default_nettype none
// Base-36 encoder for unsigned 128-bit numbers.
//
// Command channel: present value_high/value_low and raise start; the
// transaction is taken at a rising edge with start high and busy low.
// busy stays high until the last character has been read out.
//
// Result channel: each character appears for one cycle with strobe high,
// most significant digit first, lower-case alphabet 0-9a-z. last_char
// marks the final character. The receiver cannot stall the block, so
// every strobe must be taken as it comes. A zero input yields one '0'.
//
// Sequence: one shared 16-bit-slice divide-by-36 step runs once per cycle,
// one step per slice for each digit. A value with D digits (1 to 25) is
// divided digit by digit, then the digit RAM is read out top-down, and
// each character follows its RAM read. busy stays high through the divide
// and read phases; with start held high the next transaction is taken
// once busy drops, so a new number is taken only after the last read.
//
// Reset (arst_n low) returns the sequencer to idle and drops any pending
// character; the digit RAM holds no reset value and needs none.
module base36_encode_128_unit #(
	parameter int unsigned MAX_DIGITS = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [63:0]                 value_high,
	input  wire logic [63:0]                 value_low,
	output logic                             strobe,
	output logic [b36e_pkg::CHAR_W-1:0]      char_code,
	output logic                             last_char
);

	localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
	localparam logic [b36e_pkg::SLICE_IDXW-1:0] SLICE_LAST =
		b36e_pkg::SLICE_IDXW'(b36e_pkg::SLICES - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;

	// quotient shift register: the top slice feeds the divider, the new
	// quotient slice enters at the bottom; after eight steps it is whole
	logic [b36e_pkg::VALUE_W-1:0]    resid_q;
	logic [b36e_pkg::DIGIT_W-1:0]    rem_q;
	logic                            qnz_q;
	logic [b36e_pkg::SLICE_IDXW-1:0] slice_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [IDX_W-1:0]                rd_idx_q;

	logic                            strobe_s1;
	logic                            last_s1;
	logic [b36e_pkg::DIGIT_W-1:0]    digit_s1;

	b36e_pkg::div_res_t              step_res;
	logic                            accept;
	logic                            digit_done;
	logic                            quot_nz;
	logic                            rd_en;

	assign accept     = start && !busy;
	assign digit_done = (state_q == ST_DIV) && (slice_q == SLICE_LAST);
	assign quot_nz    = qnz_q || (step_res.quot != '0);
	assign rd_en      = (state_q == ST_OUT);

	b36e_div_step u_div (
		.rem_in (rem_q),
		.slice  (resid_q[b36e_pkg::VALUE_W-1 -: b36e_pkg::SLICE_W]),
		.res    (step_res)
	);

	b36e_digit_ram #(
		.DEPTH (MAX_DIGITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (digit_done),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (step_res.rem),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (digit_s1)
	);

	// sequencer: load, divide digit by digit, then drain the RAM top-down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slice_q   <= '0;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			qnz_q     <= 1'b0;
			rem_q     <= '0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						slice_q <= '0;
						cnt_q   <= '0;
						qnz_q   <= 1'b0;
						rem_q   <= '0;
					end
				end
				ST_DIV: begin
					slice_q <= slice_q + 1'b1;
					if (digit_done) begin
						// digit stored; restart the remainder chain
						rem_q <= '0;
						qnz_q <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						if (!quot_nz || (cnt_q + 1'b1 == CNT_MAX)) begin
							state_q  <= ST_OUT;
							rd_idx_q <= cnt_q[IDX_W-1:0];
						end
					end else begin
						rem_q <= step_res.rem;
						qnz_q <= quot_nz;
					end
				end
				ST_OUT: begin
					strobe_s1 <= 1'b1;
					last_s1   <= (rd_idx_q == '0);
					if (rd_idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: load on accept, advance one slice per divide cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			resid_q <= {value_high, value_low};
		end else if (state_q == ST_DIV) begin
			resid_q <= {resid_q[b36e_pkg::VALUE_W-b36e_pkg::SLICE_W-1:0], step_res.quot};
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_s1;
	assign last_char = last_s1;
	assign char_code = b36e_pkg::glyph(digit_s1);

	// a character only follows a RAM read cycle
	a_strobe_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_OUT))
		else $error("strobe without a preceding digit read");

	// an accepted transaction always enters the divide phase
	a_accept_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_DIV) && (cnt_q == '0))
		else $error("accepted transaction did not start dividing");

	// the digit count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("digit count overflow");

	// the final mark comes with a strobe and returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> strobe && (state_q == ST_IDLE))
		else $error("last character out of step with the sequencer");

endmodule
`default_nettype wire

@@ verif/base36_encode_128_unit_test.sv @@
`default_nettype none
module base36_encode_128_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TEXT_MAX = 25;
	localparam int unsigned RANDOM_NUMBERS = 347;
	localparam int unsigned TAIL_CYCLES = 40;

	// One character of the expected base-36 text.
	typedef struct packed {
		logic [b36e_pkg::CHAR_W-1:0] code;
		logic                        last;
	} text_char_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [63:0]        value_high = '0;
	logic [63:0]        value_low = '0;
	logic               busy;
	logic               strobe;
	logic [b36e_pkg::CHAR_W-1:0] char_code;
	logic               last_char;

	// Numbers waiting to be sent and characters waiting to come back.
	logic [127:0]       number_queue[$];
	text_char_t         pending_chars[$];

	int unsigned        errors = 0;
	int unsigned        wait_left = 0;
	int unsigned        burst_left = 0;

	base36_encode_128_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value_high (value_high),
		.value_low  (value_low),
		.strobe     (strobe),
		.char_code  (char_code),
		.last_char  (last_char)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ASCII for one base-36 digit: 0-9 then lower-case a-z.
	function automatic logic [b36e_pkg::CHAR_W-1:0] digit_char(input logic [5:0] d);
		logic [7:0] c;
		if (d < 6'd10) begin
			c = 8'h30 + {2'b00, d};
		end else begin
			c = 8'h61 + {2'b00, d} - 8'd10;
		end
		return c[b36e_pkg::CHAR_W-1:0];
	endfunction

	// Convert the number by repeated division and queue its text, most
	// significant character first. Zero falls out as the single digit '0'.
	function automatic void predict_text(input logic [127:0] number);
		logic [127:0] rest;
		logic [5:0]   digits[TEXT_MAX];
		int unsigned  n;
		text_char_t   ch;
		rest = number;
		n = 0;
		do begin
			digits[n] = 6'(rest % 128'd36);
			rest = rest / 128'd36;
			n++;
		end while (rest != 0 && n < TEXT_MAX);
		for (int k = n - 1; k >= 0; k--) begin
			ch.code = digit_char(digits[k]);
			ch.last = (k == 0);
			pending_chars.push_back(ch);
		end
	endfunction

	function automatic logic [127:0] pow36(input int unsigned k);
		logic [127:0] p;
		p = 128'd1;
		for (int unsigned i = 0; i < k; i++) begin
			p = p * 128'd36;
		end
		return p;
	endfunction

	function automatic logic [127:0] rand_wide();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Pick a number for the random phase. Favor short texts so the run
	// stays quick; full-width values and digit-count boundaries still
	// show up regularly.
	function automatic logic [127:0] rand_number();
		logic [127:0] v;
		int unsigned  k;
		case ($urandom_range(0, 9))
			0, 1: begin
				v = rand_wide();
			end
			2, 3, 4, 5: begin
				// random bit length, top bit set
				k = $urandom_range(1, 128);
				v = rand_wide() >> (128 - k);
				v[k-1] = 1'b1;
			end
			6: begin
				v = 128'($urandom_range(0, 1295));
			end
			7: begin
				// straddle a digit-count boundary
				k = $urandom_range(1, 24);
				v = pow36(k) - 128'd1 + 128'($urandom_range(0, 2));
			end
			8: begin
				// all-'z' text of random length
				v = pow36($urandom_range(1, 24)) - 128'd1;
			end
			default: begin
				k = $urandom_range(0, 23);
				v = pow36(k) * 128'($urandom_range(1, 35)) + 128'($urandom_range(0, 35));
			end
		endcase
		return v;
	endfunction

	// Idle cycles before the next command. Now and then switch into a
	// run of back-to-back commands with no idling at all.
	function automatic int unsigned draw_gap();
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			burst_left = $urandom_range(5, 20);
		end
		return $urandom_range(0, 5);
	endfunction

	// Command driver. On an accepted transaction, predict its text, then
	// either keep start high with the next number or drop it and count
	// down an idle gap. The gap only runs while the block is idle, so it
	// lands after busy drops, never inside busy.
	always @(posedge clk) begin : drive_numbers
		int unsigned  gap;
		logic [127:0] next_num;
		if (!arst_n) begin
			start <= 1'b0;
			wait_left <= 0;
		end else if (start && !busy) begin
			predict_text({value_high, value_low});
			gap = draw_gap();
			if (gap == 0 && number_queue.size() != 0) begin
				next_num = number_queue.pop_front();
				value_high <= next_num[127:64];
				value_low <= next_num[63:0];
			end else begin
				start <= 1'b0;
				wait_left <= gap;
			end
		end else if (!start && !busy) begin
			if (wait_left != 0) begin
				// hold start low; wiggle the operands so only the
				// accepting edge matters
				wait_left <= wait_left - 1;
				value_high <= {$urandom, $urandom};
				value_low <= {$urandom, $urandom};
			end else if (number_queue.size() != 0) begin
				next_num = number_queue.pop_front();
				value_high <= next_num[127:64];
				value_low <= next_num[63:0];
				start <= 1'b1;
			end
		end
	end

	// Character monitor. The receiver cannot stall, so take every strobe
	// and match it against the oldest expected character.
	always @(posedge clk) begin : check_chars
		text_char_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual code 0x%0h last %0b",
					$time, char_code, last_char);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.code) begin
					$display("%0t: char_code mismatch: expected 0x%0h, actual 0x%0h",
						$time, want.code, char_code);
					errors++;
				end
				if (last_char !== want.last) begin
					$display("%0t: last_char mismatch: expected %0b, actual %0b",
						$time, want.last, last_char);
					errors++;
				end
			end
		end
	end

	initial begin
		// Directed: zero, single digits, digit-count boundaries, word
		// boundaries, the largest values and alternating bit patterns.
		number_queue.push_back(128'd0);
		number_queue.push_back(128'd1);
		number_queue.push_back(128'd9);
		number_queue.push_back(128'd10);
		number_queue.push_back(128'd35);
		number_queue.push_back(128'd36);
		number_queue.push_back(128'd37);
		number_queue.push_back(128'd1295);
		number_queue.push_back(128'd1296);
		number_queue.push_back(128'hFFFF_FFFF);
		number_queue.push_back(128'h1_0000_0000);
		number_queue.push_back({64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
		number_queue.push_back({64'd1, 64'd0});
		number_queue.push_back(pow36(12) - 128'd1);
		number_queue.push_back(pow36(12));
		number_queue.push_back(pow36(23) * 128'd35);
		number_queue.push_back(pow36(24) - 128'd1);
		number_queue.push_back(pow36(24));
		number_queue.push_back({64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
		number_queue.push_back({128{1'b1}});
		number_queue.push_back({64{2'b10}});
		number_queue.push_back({64{2'b01}});
		number_queue.push_back({1'b1, 127'd0});
		for (int unsigned i = 0; i < RANDOM_NUMBERS; i++) begin
			number_queue.push_back(rand_number());
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last command to be taken, then for its text.
		while (number_queue.size() != 0 || start) @(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && pending_chars.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: well beyond every number taking 25 digits plus idle gaps.
	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
